// ===== src/debug_packet_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// debug_packet_deframer_defines
// assertion macros shared by the deframer modules
// ----------------------------------------------------------------------------
`ifndef DEBUG_PACKET_DEFRAMER_DEFINES_SVH
`define DEBUG_PACKET_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge outside reset
`define DPD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deframer assertion failed");

// property checked on the edge after a trigger
`define DPD_ASSERT_NEXT(label, clk, rst_n, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("deframer assertion failed");

`else

`define DPD_ASSERT(label, clk, rst_n, prop)
`define DPD_ASSERT_NEXT(label, clk, rst_n, trig, prop)

`endif

`endif

// ===== src/dpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dpd_pkg
// types, codes and helpers for the debug packet deframer
// ----------------------------------------------------------------------------
package dpd_pkg;

    localparam int unsigned DATA_W          = 8;
    localparam int unsigned STATUS_W        = 3;
    localparam int unsigned PHASE_W         = 3;
    localparam int unsigned DIGITS_W        = 2;
    localparam int unsigned S_TDATA_W       = 8;
    localparam int unsigned M_TDATA_W       = 16;
    localparam int unsigned FIFO_DEPTH_DEF  = 4;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_START    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PACKET   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ESCAPE   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CHECKSUM = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE     = 3'd4;

    // verdict codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DOLLAR     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADDIGIT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISMATCH   = 3'd4;

    // framing characters
    localparam logic [DATA_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [DATA_W-1:0] CH_HASH    = 8'h23;
    localparam logic [DATA_W-1:0] CH_ESCAPE  = 8'h7D;
    localparam logic [DATA_W-1:0] ESC_XOR    = 8'h20;
    localparam logic [DIGITS_W-1:0] DIGITS_RST = 2'd2;

    // results caused by one input byte
    typedef struct packed {
        logic                pay_vld;
        logic [DATA_W-1:0]   pay;
        logic                ver_vld;
        logic [STATUS_W-1:0] status;
    } dpd_entry_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } dpd_hex_t;

    function automatic dpd_hex_t hex_decode(input logic [DATA_W-1:0] c);
        dpd_hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            h.value = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            h.value = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66)
            h.value = 4'(c - 8'h57);
        else
            h.ok = 1'b0;
        return h;
    endfunction

endpackage

// ===== src/dpd_parser.sv =====
// ----------------------------------------------------------------------------
// dpd_parser
// input beat register, packet state and per-byte decode
// ----------------------------------------------------------------------------
`include "debug_packet_deframer_defines.svh"

module dpd_parser
    import dpd_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF,
    parameter int unsigned CNT_W = $clog2(FIFO_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_byte,
    input  logic              in_last,
    input  logic [CNT_W-1:0]  fifo_level,
    output logic              push,
    output dpd_entry_t        push_entry
);

    logic                in_valid_reg;
    logic [DATA_W-1:0]   in_byte_reg;
    logic                in_last_reg;

    logic [PHASE_W-1:0]  phase_reg, phase_next, phase_s;
    logic [DATA_W-1:0]   run_sum_reg, run_sum_next, run_sum_s;
    logic [DATA_W-1:0]   rx_sum_reg, rx_sum_next, rx_sum_s;
    logic [DIGITS_W-1:0] digits_reg, digits_next, digits_s;
    logic [STATUS_W-1:0] err_reg, err_next, err_s;

    dpd_hex_t            hex;
    logic                pay_vld;
    logic [DATA_W-1:0]   pay;
    logic [STATUS_W-1:0] verdict;

    // room for the beat in flight and the one taken now
    assign in_ready = ({1'b0, fifo_level} + (CNT_W+1)'(in_valid_reg))
                      < (CNT_W+1)'(FIFO_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid && in_ready;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    assign hex = hex_decode(in_byte_reg);

    always_comb
    begin
        phase_s   = phase_reg;
        run_sum_s = run_sum_reg;
        rx_sum_s  = rx_sum_reg;
        digits_s  = digits_reg;
        err_s     = err_reg;
        pay_vld   = 1'b0;
        pay       = '0;
        if (err_reg == ST_OK)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (in_byte_reg == CH_DOLLAR)
                        phase_s = PH_PACKET;
                end
                PH_PACKET:
                begin
                    if (in_byte_reg == CH_DOLLAR)
                        err_s = ST_DOLLAR;
                    else if (in_byte_reg == CH_HASH)
                        phase_s = PH_CHECKSUM;
                    else
                    begin
                        if (in_byte_reg == CH_ESCAPE)
                            phase_s = PH_ESCAPE;
                        else
                        begin
                            pay_vld = 1'b1;
                            pay     = in_byte_reg;
                        end
                        run_sum_s = run_sum_reg + in_byte_reg;
                    end
                end
                PH_ESCAPE:
                begin
                    pay_vld   = 1'b1;
                    pay       = in_byte_reg ^ ESC_XOR;
                    run_sum_s = run_sum_reg + in_byte_reg;
                    phase_s   = PH_PACKET;
                end
                PH_CHECKSUM:
                begin
                    if (!hex.ok)
                        err_s = ST_BADDIGIT;
                    else
                    begin
                        rx_sum_s = {rx_sum_reg[DATA_W-5:0], hex.value};
                        digits_s = digits_reg - 2'd1;
                        if (digits_reg == 2'd1)
                            phase_s = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        priority if (err_s != ST_OK)
            verdict = err_s;
        else if (phase_s != PH_DONE)
            verdict = ST_INCOMPLETE;
        else if (run_sum_s != rx_sum_s)
            verdict = ST_MISMATCH;
        else
            verdict = ST_OK;

        phase_next   = phase_reg;
        run_sum_next = run_sum_reg;
        rx_sum_next  = rx_sum_reg;
        digits_next  = digits_reg;
        err_next     = err_reg;
        if (in_valid_reg)
        begin
            if (in_last_reg)
            begin
                // buffer done: back to the reset state
                phase_next   = PH_START;
                run_sum_next = '0;
                rx_sum_next  = '0;
                digits_next  = DIGITS_RST;
                err_next     = ST_OK;
            end
            else
            begin
                phase_next   = phase_s;
                run_sum_next = run_sum_s;
                rx_sum_next  = rx_sum_s;
                digits_next  = digits_s;
                err_next     = err_s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            run_sum_reg <= '0;
            rx_sum_reg  <= '0;
            digits_reg  <= DIGITS_RST;
            err_reg     <= ST_OK;
        end
        else
        begin
            phase_reg   <= phase_next;
            run_sum_reg <= run_sum_next;
            rx_sum_reg  <= rx_sum_next;
            digits_reg  <= digits_next;
            err_reg     <= err_next;
        end
    end

    assign push               = in_valid_reg && (pay_vld || in_last_reg);
    assign push_entry.pay_vld = pay_vld;
    assign push_entry.pay     = pay;
    assign push_entry.ver_vld = in_last_reg;
    assign push_entry.status  = verdict;

    `DPD_ASSERT(a_no_pay_after_error, clk, rst_n, (err_reg != ST_OK) |-> !pay_vld)
    `DPD_ASSERT_NEXT(a_reset_after_last, clk, rst_n, in_valid_reg && in_last_reg,
                     phase_reg == PH_START && err_reg == ST_OK && digits_reg == DIGITS_RST)
    `DPD_ASSERT(a_error_keeps_phase, clk, rst_n,
                (in_valid_reg && !in_last_reg && err_reg != ST_OK) |=> $stable(phase_reg))

endmodule

// ===== src/dpd_out_queue.sv =====
// ----------------------------------------------------------------------------
// dpd_out_queue
// result queue; splits an entry into its payload and verdict beats
// ----------------------------------------------------------------------------
`include "debug_packet_deframer_defines.svh"

module dpd_out_queue
    import dpd_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF,
    parameter int unsigned CNT_W = $clog2(FIFO_DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dpd_entry_t           push_entry,
    output logic [CNT_W-1:0]     level,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_W-1:0]    out_byte,
    output logic [STATUS_W-1:0]  out_status,
    output logic                 out_last
);

    localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    dpd_entry_t       mem_reg [FIFO_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             second_reg, second_next;
    dpd_entry_t       head;
    logic             pay_beat;
    logic             pop;

    assign head      = mem_reg[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    // payload beat goes first, verdict beat follows it
    assign pay_beat  = head.pay_vld && !second_reg;
    assign out_byte  = pay_beat ? head.pay : '0;
    assign out_status = pay_beat ? ST_OK : head.status;
    assign out_last  = !pay_beat;
    assign pop       = out_valid && out_ready && (!pay_beat || !head.ver_vld);
    assign level     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        second_next = second_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            second_next = 1'b0;
        end
        else if (out_valid && out_ready)
            second_next = 1'b1;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            second_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    `DPD_ASSERT(a_no_overflow, clk, rst_n, push |-> (count_reg < CNT_W'(FIFO_DEPTH)) || pop)
    `DPD_ASSERT(a_head_has_beat, clk, rst_n, out_valid |-> (head.pay_vld || head.ver_vld))
    `DPD_ASSERT(a_second_only_verdict, clk, rst_n, second_reg |-> (out_valid && head.ver_vld))

endmodule

// ===== src/debug_packet_deframer.sv =====
// path: an accepted byte is held in the parser's input beat register, then written into the result queue
// throughput: one byte per cycle while the result queue has room; a byte carrying both a payload and a verdict
//   needs two output beats, set by the single-read result queue
// reset: rst_n clears the parse state and empties the result queue at once
// ----------------------------------------------------------------------------
// debug_packet_deframer
// deframes $payload#hh debugger packets, one received byte per beat
// ----------------------------------------------------------------------------
module debug_packet_deframer
    import dpd_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte
    input  logic                 s_tlast,   // buffer_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] payload_byte, [10:8] status, rest zero
    output logic                 m_tlast    // is_verdict
);

    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [CNT_W-1:0]    level;
    logic                push;
    dpd_entry_t          push_entry;
    logic [DATA_W-1:0]   out_byte;
    logic [STATUS_W-1:0] out_status;

    dpd_parser #(
        .CNT_W      (CNT_W),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .fifo_level (level),
        .push       (push),
        .push_entry (push_entry)
    );

    dpd_out_queue #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .CNT_W      (CNT_W)
    ) u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .level      (level),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    assign m_tdata = {(M_TDATA_W - DATA_W - STATUS_W)'(0), out_status, out_byte};

endmodule

// ===== sim/debug_packet_deframer_chk.sv =====
// ----------------------------------------------------------------------------
// debug_packet_deframer_chk
// watches both stream channels of the deframer, tracks the packet parse for
// every accepted input beat and checks each output beat against the oldest
// predicted result
// ----------------------------------------------------------------------------
module debug_packet_deframer_chk
    import dpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte
    input  logic                 s_tlast,   // buffer_end
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [7:0] payload_byte, [10:8] status, rest zero
    input  logic                 m_tlast,   // is_verdict
    output int                   fail_count,
    output int                   beats_pending,
    output int                   payload_beats,
    output int                   verdict_beats,
    output logic [4:0]           codes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0]   pay;
        logic [STATUS_W-1:0] status;
        logic                verdict;
    } result_t;

    result_t results_due[$];

    logic [PHASE_W-1:0]  phase;
    logic [DATA_W-1:0]   run_sum;
    logic [DATA_W-1:0]   rx_sum;
    logic [DIGITS_W-1:0] digits;
    logic [STATUS_W-1:0] err;

    // bit 4 set when the byte is no hex digit
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b0, 4'(c - "0")};
        if (c >= "A" && c <= "F")
            return {1'b0, 4'(c - "A" + 8'd10)};
        if (c >= "a" && c <= "f")
            return {1'b0, 4'(c - "a" + 8'd10)};
        return 5'h10;
    endfunction

    task automatic clear_parse();
        phase   = PH_START;
        run_sum = '0;
        rx_sum  = '0;
        digits  = DIGITS_RST;
        err     = ST_OK;
    endtask

    task automatic deframe_byte(input logic [7:0] c, input logic eob);
        logic [4:0] d;
        result_t    r;
        logic       emit;
        emit = 1'b0;
        r    = '0;
        if (err == ST_OK)
        begin
            case (phase)
                PH_START:
                begin
                    if (c == CH_DOLLAR)
                        phase = PH_PACKET;
                end
                PH_PACKET:
                begin
                    if (c == CH_DOLLAR)
                        err = ST_DOLLAR;
                    else if (c == CH_HASH)
                        phase = PH_CHECKSUM;
                    else
                    begin
                        if (c == CH_ESCAPE)
                            phase = PH_ESCAPE;
                        else
                        begin
                            emit  = 1'b1;
                            r.pay = c;
                        end
                        run_sum = run_sum + c;
                    end
                end
                PH_ESCAPE:
                begin
                    // any byte here is data, a dollar too
                    emit    = 1'b1;
                    r.pay   = c ^ ESC_XOR;
                    run_sum = run_sum + c;
                    phase   = PH_PACKET;
                end
                PH_CHECKSUM:
                begin
                    d = digit_of(c);
                    if (d[4])
                        err = ST_BADDIGIT;
                    else
                    begin
                        rx_sum = {rx_sum[3:0], d[3:0]};
                        digits = digits - 1'b1;
                        if (digits == 0)
                            phase = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (emit)
            results_due.insert(results_due.size(), r);
        if (eob)
        begin
            r         = '0;
            r.verdict = 1'b1;
            if (err != ST_OK)
                r.status = err;
            else if (phase != PH_DONE)
                r.status = ST_INCOMPLETE;
            else if (run_sum != rx_sum)
                r.status = ST_MISMATCH;
            else
                r.status = ST_OK;
            results_due.insert(results_due.size(), r);
            clear_parse();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            clear_parse();
            results_due.delete();
            beats_pending = 0;
            codes_seen    = '0;
        end
        else
        begin
            // output first, so a beat never meets an expectation made at the same edge
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected output beat, got payload %02h status %0d last %0b",
                             $time, m_tdata[7:0], m_tdata[10:8], m_tlast);
                end
                else
                begin
                    e = results_due.pop_front();
                    if (m_tdata[7:0] !== e.pay || m_tdata[10:8] !== e.status ||
                        m_tdata[15:11] !== '0 || m_tlast !== e.verdict)
                    begin
                        fail_count++;
                        $display({"%0t: output mismatch, expected payload %02h status %0d ",
                                  "last %0b, got tdata %04h last %0b"},
                                 $time, e.pay, e.status, e.verdict, m_tdata, m_tlast);
                    end
                    if (e.verdict)
                    begin
                        verdict_beats++;
                        codes_seen[e.status] = 1'b1;
                    end
                    else
                        payload_beats++;
                end
            end
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata, s_tlast);
            beats_pending = results_due.size();
        end
    end

endmodule

// ===== sim/tb_debug_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_debug_packet_deframer
// drives directed and random packet buffers into the deframer under three
// pacing phases and reports the verdict from the checker's failure count
// ----------------------------------------------------------------------------
module tb_debug_packet_deframer;
    import dpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int PHASE_ITEMS    = 450;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 16;
    localparam logic MID = 1'b0;
    localparam logic EOB = 1'b1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;      // [7:0] rx_byte
    logic                 s_tlast;      // buffer_end
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;      // [7:0] payload_byte, [10:8] status, rest zero
    logic                 m_tlast;      // is_verdict

    int         fail_count;
    int         beats_pending;
    int         payload_beats;
    int         verdict_beats;
    logic [4:0] codes_seen;

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int bytes_sent    = 0;
    int quiet_cycles  = 0;

    logic [8:0] directed [0:26];

    always #(CLK_PERIOD / 2) clk = ~clk;

    debug_packet_deframer dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    debug_packet_deframer_chk deframe_chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .beats_pending (beats_pending),
        .payload_beats (payload_beats),
        .verdict_beats (verdict_beats),
        .codes_seen    (codes_seen)
    );

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
                $display("debug_packet_deframer regression: fail");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic eob);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eob;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return "0" + n;
        if ($urandom_range(0, 1) == 0)
            return "a" + n - 8'd10;
        return "A" + n - 8'd10;
    endfunction

    // one buffer: mostly a well-formed packet, now and then a broken one
    task automatic send_frame();
        logic [7:0] frame[$];
        logic [7:0] sum;
        logic [7:0] c;
        int         kind;
        int         len;
        int         cut;
        kind = $urandom_range(0, 99);
        sum  = '0;
        if (kind >= 98)
        begin
            // loose noise with random buffer ends
            repeat ($urandom_range(1, 6))
                send_beat(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
            return;
        end
        repeat ($urandom_range(0, 2))
        begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_DOLLAR)
                c = c ^ 8'h01;
            frame = {frame, c};
        end
        frame = {frame, CH_DOLLAR};
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
        for (int i = 0; i < len; i++)
        begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_DOLLAR || c == CH_HASH || c == CH_ESCAPE || $urandom_range(0, 7) == 0)
            begin
                frame = {frame, CH_ESCAPE};
                frame = {frame, c ^ ESC_XOR};
                sum = sum + CH_ESCAPE + (c ^ ESC_XOR);
            end
            else
            begin
                frame = {frame, c};
                sum = sum + c;
            end
        end
        if (kind >= 78 && kind < 84)
            frame.insert($urandom_range(1, frame.size()), CH_DOLLAR);
        else if (kind >= 84 && kind < 88)
            frame = {frame, CH_ESCAPE};     // escapes the hash that follows
        else if (kind >= 88 && kind < 92)
            sum = sum ^ (8'h01 << $urandom_range(0, 7));
        frame = {frame, CH_HASH};
        frame = {frame, hex_char(sum[7:4])};
        frame = {frame, hex_char(sum[3:0])};
        if (kind >= 92 && kind < 96)
        begin
            c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h67, 8'hFF))
                                            : 8'($urandom_range(8'h00, 8'h2F));
            frame[frame.size() - 1 - $urandom_range(0, 1)] = c;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                frame = {frame, 8'($urandom_range(0, 255))};
        if (kind >= 96)
        begin
            cut = $urandom_range(1, frame.size() - 1);
            frame = frame[0:cut-1];
        end
        foreach (frame[i])
            send_beat(frame[i], (i == frame.size() - 1));
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;

        // empty packet; escapes with an escaped dollar; stray dollar; bad digit;
        // incomplete; mismatch with trailing bytes
        directed = '{
            {MID, CH_DOLLAR}, {MID, CH_HASH}, {MID, "0"}, {EOB, "0"},
            {MID, 8'h00}, {MID, CH_DOLLAR}, {MID, 8'hFF}, {MID, CH_ESCAPE},
            {MID, CH_DOLLAR}, {MID, CH_HASH}, {MID, "A"}, {EOB, "0"},
            {MID, CH_DOLLAR}, {MID, "a"}, {MID, CH_DOLLAR}, {EOB, "b"},
            {MID, CH_DOLLAR}, {MID, CH_HASH}, {EOB, "g"},
            {MID, CH_DOLLAR}, {MID, CH_HASH}, {EOB, "a"},
            {MID, CH_DOLLAR}, {MID, CH_HASH}, {MID, "0"}, {MID, "1"}, {EOB, "x"}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    src_idle_pct   = 28;
                    sink_stall_pct = 78;
                end
                1:
                begin
                    src_idle_pct   = 78;
                    sink_stall_pct = 28;
                end
                default:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            if (p == 0)
                foreach (directed[i])
                    send_beat(directed[i][7:0], directed[i][8]);
            while (bytes_sent < 27 + PHASE_ITEMS * (p + 1))
                send_frame();
        end
        s_tvalid <= 1'b0;

        while (beats_pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("run covered %0d input bytes under three pacing phases", bytes_sent);
        $display("checked %0d payload beats and %0d verdicts, verdict codes seen %05b",
                 payload_beats, verdict_beats, codes_seen);
        if (fail_count == 0)
            $display("debug_packet_deframer regression: pass");
        else
            $display("debug_packet_deframer regression: fail");
        $finish;
    end

endmodule
